// ----- rtl/sfs_pkg.sv -----
// Shared types and constants of the 2x2 scale-factor solver.
package sfs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int TEXT_W        = 31;
    localparam int MAG_W         = 64;
    localparam int QUO_W         = 34;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [3:0] {
        CASE_UNIQUE    = 4'd0,
        CASE_YFIT_BOTH = 4'd1,
        CASE_YFIT_V    = 4'd2,
        CASE_XFIT_BOTH = 4'd3,
        CASE_XFIT_H    = 4'd4,
        CASE_AVG       = 4'd5,
        CASE_XRATIO    = 4'd6,
        CASE_YRATIO    = 4'd7,
        CASE_KEEP      = 4'd8
    } case_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET     = 3'd0,
        REG_X_PER_HSCALE = 3'd1,
        REG_X_PER_VSCALE = 3'd2,
        REG_X_PER_TEXTW  = 3'd3,
        REG_Y_OFFSET     = 3'd4,
        REG_Y_PER_HSCALE = 3'd5,
        REG_Y_PER_VSCALE = 3'd6,
        REG_Y_PER_TEXTH  = 3'd7
    } reg_idx_t;

    // Per-item side data carried alongside the dividers
    typedef struct packed {
        case_t              code;
        logic signed [31:0] hs;
        logic signed [31:0] vs;
        logic               satx;
        logic               saty;
        logic               neg_a;
        logic               neg_b;
    } side_t;

endpackage

// ----- rtl/sfs_if.sv -----
// Request and response channel interfaces of the scale-factor solver.
interface sfs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] cur_hscale;
    logic signed [31:0] cur_vscale;
    logic [30:0]        text_width;
    logic [30:0]        text_height;
    logic               keep_x;
    logic               keep_y;

    modport source (
        output valid, target_x, target_y, origin_x, origin_y, cur_hscale, cur_vscale,
               text_width, text_height, keep_x, keep_y,
        input  ready
    );
    modport sink (
        input  valid, target_x, target_y, origin_x, origin_y, cur_hscale, cur_vscale,
               text_width, text_height, keep_x, keep_y,
        output ready
    );
endinterface

interface sfs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_hscale;
    logic signed [31:0] new_vscale;
    logic [3:0]         case_taken;
    logic               saturated;

    modport source (
        output valid, new_hscale, new_vscale, case_taken, saturated,
        input  ready
    );
    modport sink (
        input  valid, new_hscale, new_vscale, case_taken, saturated,
        output ready
    );
endinterface

// ----- rtl/scale_factor_solver_2x2_core.sv -----
// Top level of the 2x2 scale-factor solver pipeline.
//
//  channel | dir | word
//  --------+-----+-----------------------------------------------------------
//  req     | in  | target, origin, current scales, text size, keep flags
//  rsp     | out | new scales, case taken, saturated flag
//  cfg     | in  | register index and 32-bit data, write enable
//
// One word is accepted every cycle while no result is held on rsp.
// The pipeline is built from the two 35-stage quotient dividers (a seed stage,
// then one bit a stage) plus nine stages of multiply, sum, select, rounding,
// scaling and the result register.
// Reset clears the valid bits and the coefficient registers to zero.
// The whole pipeline holds while a result waits on rsp, so nothing is lost
// or repeated; req.ready follows that hold.
module scale_factor_solver_2x2_core #(
    parameter int FRAC_BITS = sfs_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfs_pkg::DATA_W-1:0]     cfg_wdata,
    sfs_in_if.sink                         req,
    sfs_out_if.source                      rsp
);
    import sfs_pkg::*;

    localparam int NW   = MAG_W + 2 * FRAC_BITS + 1;
    localparam int DLAT = QUO_W + 1;
    localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] HALF_M1 = HALF - 64'sd1;

    // Round half away from zero to the integer grid of FRAC_BITS
    function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? HALF_M1 : HALF);
        return t >>> FRAC_BITS;
    endfunction

    // Saturate to 32 bits; flag in the top bit
    function automatic logic [32:0] clip32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sh7FFFFFFF)
            r = {1'b1, 32'h7FFFFFFF};
        else if (v < -64'sh80000000)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    function automatic logic [63:0] mag65(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = v[64] ? -v : v;
        return t[63:0];
    endfunction

    // Round a quotient with one guard bit, apply sign, saturate
    function automatic logic [32:0] qfix(input logic [QUO_W-1:0] q, input logic ovf,
                                         input logic neg);
        logic [QUO_W:0]   s;
        logic [QUO_W-1:0] m;
        logic [32:0]      r;
        s = {1'b0, q} + {{QUO_W{1'b0}}, 1'b1};
        m = s[QUO_W:1];
        if (ovf)
            r = neg ? {1'b1, 32'h80000000} : {1'b1, 32'h7FFFFFFF};
        else if (neg)
            r = (m > QUO_W'(64'h80000000)) ? {1'b1, 32'h80000000}
                                          : {1'b0, -m[31:0]};
        else
            r = (m > QUO_W'(64'h7FFFFFFF)) ? {1'b1, 32'h7FFFFFFF}
                                          : {1'b0, m[31:0]};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    logic signed [31:0] xo_reg, xh_reg, xv_reg, xtw_reg;
    logic signed [31:0] yo_reg, yh_reg, yv_reg, yth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xo_reg  <= '0;
            xh_reg  <= '0;
            xv_reg  <= '0;
            xtw_reg <= '0;
            yo_reg  <= '0;
            yh_reg  <= '0;
            yv_reg  <= '0;
            yth_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_X_OFFSET:     xo_reg  <= cfg_wdata;
                REG_X_PER_HSCALE: xh_reg  <= cfg_wdata;
                REG_X_PER_VSCALE: xv_reg  <= cfg_wdata;
                REG_X_PER_TEXTW:  xtw_reg <= cfg_wdata;
                REG_Y_OFFSET:     yo_reg  <= cfg_wdata;
                REG_Y_PER_HSCALE: yh_reg  <= cfg_wdata;
                REG_Y_PER_VSCALE: yv_reg  <= cfg_wdata;
                REG_Y_PER_TEXTH:  yth_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline hold
    // ------------------------------------------------------------------
    logic rsp_vld_reg;
    logic en;

    assign en        = !rsp_vld_reg || rsp.ready;
    assign req.ready = en;

    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    logic [DLAT-1:0] dl_vld_reg;
    logic f_vld_reg, g_vld_reg, h_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            dl_vld_reg  <= '0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= req.valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            dl_vld_reg  <= {dl_vld_reg[DLAT-2:0], e_vld_reg};
            f_vld_reg   <= dl_vld_reg[DLAT-1];
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            rsp_vld_reg <= h_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: products of the inputs with the coefficients
    // ------------------------------------------------------------------
    logic signed [63:0] a_ptw_reg, a_pth_reg;
    logic signed [33:0] a_dx_reg, a_dy_reg;
    logic signed [63:0] a_xhyv_reg, a_xvyh_reg, a_hsxh_reg, a_vsxv_reg;
    logic signed [63:0] a_hsyh_reg, a_vsyv_reg;
    logic signed [31:0] a_hs_reg, a_vs_reg;
    logic               a_kx_reg, a_ky_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ptw_reg  <= $signed({1'b0, req.text_width}) * xtw_reg;
            a_pth_reg  <= $signed({1'b0, req.text_height}) * yth_reg;
            a_dx_reg   <= 34'(req.target_x) - 34'(req.origin_x) - 34'(xo_reg);
            a_dy_reg   <= 34'(req.target_y) - 34'(req.origin_y) - 34'(yo_reg);
            a_xhyv_reg <= xh_reg * yv_reg;
            a_xvyh_reg <= xv_reg * yh_reg;
            a_hsxh_reg <= req.cur_hscale * xh_reg;
            a_vsxv_reg <= req.cur_vscale * xv_reg;
            a_hsyh_reg <= req.cur_hscale * yh_reg;
            a_vsyv_reg <= req.cur_vscale * yv_reg;
            a_hs_reg   <= req.cur_hscale;
            a_vs_reg   <= req.cur_vscale;
            a_kx_reg   <= req.keep_x;
            a_ky_reg   <= req.keep_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: residuals, determinant and projected sums
    // ------------------------------------------------------------------
    logic [32:0] xx_next, yy_next;

    assign xx_next = clip32(64'(a_dx_reg) - rnd_q(a_ptw_reg));
    assign yy_next = clip32(64'(a_dy_reg) - rnd_q(a_pth_reg));

    logic signed [31:0] b_xx_reg, b_yy_reg, b_hs_reg, b_vs_reg;
    logic               b_satx_reg, b_saty_reg, b_kx_reg, b_ky_reg;
    logic signed [64:0] b_det_reg, b_tpx_reg, b_tpy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_xx_reg   <= xx_next[31:0];
            b_satx_reg <= xx_next[32];
            b_yy_reg   <= yy_next[31:0];
            b_saty_reg <= yy_next[32];
            b_det_reg  <= {a_xhyv_reg[63], a_xhyv_reg} - {a_xvyh_reg[63], a_xvyh_reg};
            b_tpx_reg  <= {a_hsxh_reg[63], a_hsxh_reg} + {a_vsxv_reg[63], a_vsxv_reg};
            b_tpy_reg  <= {a_hsyh_reg[63], a_hsyh_reg} + {a_vsyv_reg[63], a_vsyv_reg};
            b_hs_reg   <= a_hs_reg;
            b_vs_reg   <= a_vs_reg;
            b_kx_reg   <= a_kx_reg;
            b_ky_reg   <= a_ky_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: pick the case, form numerator products
    // ------------------------------------------------------------------
    case_t code_next;

    always_comb
    begin
        code_next = CASE_KEEP;
        if (b_kx_reg)
        begin
            if (yh_reg != '0)
                code_next = (b_tpy_reg != '0) ? CASE_YFIT_BOTH : CASE_KEEP;
            else if (yv_reg != '0)
                code_next = CASE_YFIT_V;
        end
        else if (b_ky_reg)
        begin
            if (xv_reg != '0)
                code_next = (b_tpx_reg != '0) ? CASE_XFIT_BOTH : CASE_KEEP;
            else if (xh_reg != '0)
                code_next = CASE_XFIT_H;
        end
        else if (b_det_reg != '0)
            code_next = CASE_UNIQUE;
        else if (b_tpx_reg != '0 && b_tpy_reg != '0)
            code_next = CASE_AVG;
        else if (b_tpx_reg != '0)
            code_next = CASE_XRATIO;
        else if (b_tpy_reg != '0)
            code_next = CASE_YRATIO;
    end

    logic signed [63:0] c_xxyv_reg, c_yyxv_reg, c_yyxh_reg, c_xxyh_reg;
    logic signed [31:0] c_xx_reg, c_yy_reg;
    logic signed [64:0] c_det_reg, c_tpx_reg, c_tpy_reg;
    side_t              c_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_xxyv_reg       <= b_xx_reg * yv_reg;
            c_yyxv_reg       <= b_yy_reg * xv_reg;
            c_yyxh_reg       <= b_yy_reg * xh_reg;
            c_xxyh_reg       <= b_xx_reg * yh_reg;
            c_xx_reg         <= b_xx_reg;
            c_yy_reg         <= b_yy_reg;
            c_det_reg        <= b_det_reg;
            c_tpx_reg        <= b_tpx_reg;
            c_tpy_reg        <= b_tpy_reg;
            c_side_reg.code  <= code_next;
            c_side_reg.hs    <= b_hs_reg;
            c_side_reg.vs    <= b_vs_reg;
            c_side_reg.satx  <= b_satx_reg;
            c_side_reg.saty  <= b_saty_reg;
            c_side_reg.neg_a <= 1'b0;
            c_side_reg.neg_b <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: Cramer numerators
    // ------------------------------------------------------------------
    logic signed [64:0] d_n0_reg, d_n1_reg, d_det_reg, d_tpx_reg, d_tpy_reg;
    logic signed [31:0] d_xx_reg, d_yy_reg;
    side_t              d_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_n0_reg   <= {c_xxyv_reg[63], c_xxyv_reg} - {c_yyxv_reg[63], c_yyxv_reg};
            d_n1_reg   <= {c_yyxh_reg[63], c_yyxh_reg} - {c_xxyh_reg[63], c_xxyh_reg};
            d_det_reg  <= c_det_reg;
            d_tpx_reg  <= c_tpx_reg;
            d_tpy_reg  <= c_tpy_reg;
            d_xx_reg   <= c_xx_reg;
            d_yy_reg   <= c_yy_reg;
            d_side_reg <= c_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: choose divider operands, take magnitudes, prescale
    // ------------------------------------------------------------------
    logic signed [64:0] na, da, nb, db;
    logic               wa, wb;
    logic [63:0]        na_mag, nb_mag;
    side_t              e_side_next;

    always_comb
    begin
        na = '0;
        da = '0;
        wa = 1'b1;
        nb = '0;
        db = '0;
        wb = 1'b1;
        case (d_side_reg.code)
            CASE_UNIQUE:
            begin
                na = d_n0_reg;
                da = d_det_reg;
                wa = 1'b0;
                nb = d_n1_reg;
                db = d_det_reg;
                wb = 1'b0;
            end
            CASE_YFIT_BOTH, CASE_YRATIO:
            begin
                na = 65'(d_yy_reg);
                da = d_tpy_reg;
            end
            CASE_YFIT_V:
            begin
                na = 65'(d_yy_reg);
                da = 65'(yv_reg);
                wa = 1'b0;
            end
            CASE_XFIT_BOTH, CASE_XRATIO:
            begin
                na = 65'(d_xx_reg);
                da = d_tpx_reg;
            end
            CASE_XFIT_H:
            begin
                na = 65'(d_xx_reg);
                da = 65'(xh_reg);
                wa = 1'b0;
            end
            CASE_AVG:
            begin
                na = 65'(d_xx_reg);
                da = d_tpx_reg;
                nb = 65'(d_yy_reg);
                db = d_tpy_reg;
            end
            default: ;
        endcase
    end

    assign na_mag = mag65(na);
    assign nb_mag = mag65(nb);

    // Attach the quotient signs to the side data
    always_comb
    begin
        e_side_next       = d_side_reg;
        e_side_next.neg_a = na[64] ^ da[64];
        e_side_next.neg_b = nb[64] ^ db[64];
    end

    logic [NW-1:0] e_num_a_reg, e_num_b_reg;
    logic [63:0]   e_den_a_reg, e_den_b_reg;
    side_t         e_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_num_a_reg <= wa ? (NW'(na_mag) << (2 * FRAC_BITS + 1))
                              : (NW'(na_mag) << (FRAC_BITS + 1));
            e_num_b_reg <= wb ? (NW'(nb_mag) << (2 * FRAC_BITS + 1))
                              : (NW'(nb_mag) << (FRAC_BITS + 1));
            e_den_a_reg <= mag65(da);
            e_den_b_reg <= mag65(db);
            e_side_reg  <= e_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Dividers and the matching side-data line
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] qa, qb;
    logic             ova, ovb;

    sfs_div #(.NUM_W(NW), .DEN_W(MAG_W), .QUO_W(QUO_W)) u_div_a (
        .clk (clk),
        .en  (en),
        .num (e_num_a_reg),
        .den (e_den_a_reg),
        .quo (qa),
        .ovf (ova)
    );

    sfs_div #(.NUM_W(NW), .DEN_W(MAG_W), .QUO_W(QUO_W)) u_div_b (
        .clk (clk),
        .en  (en),
        .num (e_num_b_reg),
        .den (e_den_b_reg),
        .quo (qb),
        .ovf (ovb)
    );

    side_t dl_side_reg [DLAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_side_reg[0] <= e_side_reg;
            for (int k = 1; k < DLAT; k++)
            begin
                dl_side_reg[k] <= dl_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F: round and saturate the quotients
    // ------------------------------------------------------------------
    side_t       dl_out;
    logic [32:0] fa_next, fb_next;

    assign dl_out  = dl_side_reg[DLAT-1];
    assign fa_next = qfix(qa, ova, dl_out.neg_a);
    assign fb_next = qfix(qb, ovb, dl_out.neg_b);

    logic signed [31:0] f_fa_reg, f_fb_reg;
    logic               f_sa_reg, f_sb_reg;
    side_t              f_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_fa_reg   <= fa_next[31:0];
            f_sa_reg   <= fa_next[32];
            f_fb_reg   <= fb_next[31:0];
            f_sb_reg   <= fb_next[32];
            f_side_reg <= dl_out;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: common ratio (average where both apply)
    // ------------------------------------------------------------------
    logic signed [32:0] avg_sum, avg_rnd;

    assign avg_sum = 33'(f_fa_reg) + 33'(f_fb_reg);
    assign avg_rnd = (avg_sum + (avg_sum[32] ? 33'sd0 : 33'sd1)) >>> 1;

    logic signed [31:0] g_f_reg, g_fa_reg, g_fb_reg;
    logic               g_sa_reg, g_sb_reg;
    side_t              g_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_f_reg    <= (f_side_reg.code == CASE_AVG) ? avg_rnd[31:0] : f_fa_reg;
            g_fa_reg   <= f_fa_reg;
            g_fb_reg   <= f_fb_reg;
            g_sa_reg   <= f_sa_reg;
            g_sb_reg   <= f_sb_reg;
            g_side_reg <= f_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: scale both factors by the ratio
    // ------------------------------------------------------------------
    logic signed [63:0] h_ph_reg, h_pv_reg;
    logic signed [31:0] h_fa_reg, h_fb_reg;
    logic               h_sa_reg, h_sb_reg;
    side_t              h_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_ph_reg   <= g_side_reg.hs * g_f_reg;
            h_pv_reg   <= g_side_reg.vs * g_f_reg;
            h_fa_reg   <= g_fa_reg;
            h_fb_reg   <= g_fb_reg;
            h_sa_reg   <= g_sa_reg;
            h_sb_reg   <= g_sb_reg;
            h_side_reg <= g_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage I: round scaled factors, select the result word
    // ------------------------------------------------------------------
    logic [32:0]        sh, sv;
    logic signed [31:0] nh_next, nv_next;
    logic               sat_next, ssc;

    assign sh  = clip32(rnd_q(h_ph_reg));
    assign sv  = clip32(rnd_q(h_pv_reg));
    assign ssc = sh[32] | sv[32];

    always_comb
    begin
        nh_next  = h_side_reg.hs;
        nv_next  = h_side_reg.vs;
        sat_next = 1'b0;
        case (h_side_reg.code)
            CASE_UNIQUE:
            begin
                nh_next  = h_fa_reg;
                nv_next  = h_fb_reg;
                sat_next = h_sa_reg | h_sb_reg | h_side_reg.satx | h_side_reg.saty;
            end
            CASE_YFIT_BOTH, CASE_YRATIO:
            begin
                nh_next  = sh[31:0];
                nv_next  = sv[31:0];
                sat_next = h_sa_reg | ssc | h_side_reg.saty;
            end
            CASE_XFIT_BOTH, CASE_XRATIO:
            begin
                nh_next  = sh[31:0];
                nv_next  = sv[31:0];
                sat_next = h_sa_reg | ssc | h_side_reg.satx;
            end
            CASE_AVG:
            begin
                nh_next  = sh[31:0];
                nv_next  = sv[31:0];
                sat_next = h_sa_reg | h_sb_reg | ssc | h_side_reg.satx | h_side_reg.saty;
            end
            CASE_YFIT_V:
            begin
                nv_next  = h_fa_reg;
                sat_next = h_sa_reg | h_side_reg.saty;
            end
            CASE_XFIT_H:
            begin
                nh_next  = h_fa_reg;
                sat_next = h_sa_reg | h_side_reg.satx;
            end
            default: ;
        endcase
    end

    logic signed [31:0] rsp_nh_reg, rsp_nv_reg;
    case_t              rsp_code_reg;
    logic               rsp_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_nh_reg   <= nh_next;
            rsp_nv_reg   <= nv_next;
            rsp_code_reg <= h_side_reg.code;
            rsp_sat_reg  <= sat_next;
        end
    end

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.new_hscale = rsp_nh_reg;
    assign rsp.new_vscale = rsp_nv_reg;
    assign rsp.case_taken = rsp_code_reg;
    assign rsp.saturated  = rsp_sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("request taken while a result is held");

    a_keep_unsat: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.case_taken == CASE_KEEP) |-> !rsp.saturated)
        else $error("unchanged result flagged as saturated");

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (en && e_vld_reg) |=> dl_vld_reg[0])
        else $error("valid word lost entering the dividers");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (en && h_vld_reg) |=> rsp.valid)
        else $error("valid word lost entering the result register");

endmodule

// ----- rtl/sfs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module sfs_div #(
    parameter int NUM_W = 113,
    parameter int DEN_W = 64,
    parameter int QUO_W = 34
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);
    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic             ovf_reg [QUO_W+1];

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;

    // Detect a quotient too wide for the result and seed the remainder
    assign hi_ext  = CMP_W'(num[NUM_W-1:QUO_W]);
    assign den_ext = CMP_W'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= (hi_ext >= den_ext);
            rem_reg[0] <= hi_ext[DEN_W-1:0];
            low_reg[0] <= num[QUO_W-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    // Shift in one dividend bit, subtract where it fits
    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           fits;

        assign trial = {rem_reg[k-1], low_reg[k-1][QUO_W-k]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign fits  = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], fits};
                low_reg[k] <= low_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench of the 2x2 scale-factor solver: directed and random solves.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sfs_pkg::*;

    localparam int FB          = 16;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 60;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 85;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] tx, ty, ox, oy, hs, vs;
        logic [30:0]        tw, th;
        logic               kx, ky;
    } solve_req_t;

    typedef struct {
        logic signed [31:0] nh, nv;
        case_t              code;
        logic               sat;
    } fit_t;

    // Predicts each solve and checks results against the oldest prediction
    class fit_ledger;
        logic signed [31:0] coef[8];
        fit_t               expected_fits[$];
        int                 errors;

        function new();
            foreach (coef[i]) coef[i] = '0;
            errors = 0;
        endfunction

        function wide_t round_shift(wide_t v, int s);
            logic [127:0] m;
            m = v < 0 ? -v : v;
            m = (m + (128'd1 << (s - 1))) >> s;
            return v < 0 ? -$signed(m) : $signed(m);
        endfunction

        function wide_t clip32(wide_t v, inout bit sat);
            if (v > 128'sh7FFFFFFF) begin
                sat = 1;
                return 128'sh7FFFFFFF;
            end
            if (v < -128'sh80000000) begin
                sat = 1;
                return -128'sh80000000;
            end
            return v;
        endfunction

        // round(n * 2^s / d), saturated; d is nonzero
        function wide_t div_round(wide_t n, wide_t d, int s, inout bit sat);
            logic [127:0] nm, dm, m;
            nm = n < 0 ? -n : n;
            dm = d < 0 ? -d : d;
            m  = ((nm << (s + 1)) / dm + 1) >> 1;
            return clip32(((n < 0) != (d < 0)) ? -$signed(m) : $signed(m), sat);
        endfunction

        function wide_t scale_by(wide_t v, wide_t f, inout bit sat);
            return clip32(round_shift(v * f, FB), sat);
        endfunction

        function fit_t predict_fit(solve_req_t w);
            wide_t xoff, xph, xpv, xpt, yoff, yph, ypv, ypt;
            wide_t hs, vs, xx, yy, t, det, tpx, tpy, f, fx, fy, nh, nv;
            logic [127:0] m;
            bit satx, saty, sat;
            case_t code;
            fit_t r;
            xoff = coef[REG_X_OFFSET];  xph = coef[REG_X_PER_HSCALE];
            xpv  = coef[REG_X_PER_VSCALE]; xpt = coef[REG_X_PER_TEXTW];
            yoff = coef[REG_Y_OFFSET];  yph = coef[REG_Y_PER_HSCALE];
            ypv  = coef[REG_Y_PER_VSCALE]; ypt = coef[REG_Y_PER_TEXTH];
            hs = w.hs; vs = w.vs;
            satx = 0; saty = 0; sat = 0;
            nh = hs; nv = vs; code = CASE_KEEP; f = 0;
            xx = clip32(wide_t'(w.tx) - w.ox - xoff
                        - round_shift($signed({97'd0, w.tw}) * xpt, FB), satx);
            yy = clip32(wide_t'(w.ty) - w.oy - yoff
                        - round_shift($signed({97'd0, w.th}) * ypt, FB), saty);
            if (w.kx) begin
                if (yph != 0) begin
                    t = hs * yph + vs * ypv;
                    if (t != 0) begin
                        f = div_round(yy, t, 2 * FB, sat);
                        nh = scale_by(hs, f, sat);
                        nv = scale_by(vs, f, sat);
                        code = CASE_YFIT_BOTH;
                        sat = sat | saty;
                    end
                end else if (ypv != 0) begin
                    nv = div_round(yy, ypv, FB, sat);
                    code = CASE_YFIT_V;
                    sat = sat | saty;
                end
            end else if (w.ky) begin
                if (xpv != 0) begin
                    t = hs * xph + vs * xpv;
                    if (t != 0) begin
                        f = div_round(xx, t, 2 * FB, sat);
                        nh = scale_by(hs, f, sat);
                        nv = scale_by(vs, f, sat);
                        code = CASE_XFIT_BOTH;
                        sat = sat | satx;
                    end
                end else if (xph != 0) begin
                    nh = div_round(xx, xph, FB, sat);
                    code = CASE_XFIT_H;
                    sat = sat | satx;
                end
            end else begin
                det = xph * ypv - xpv * yph;
                if (det != 0) begin
                    nh = div_round(xx * ypv - yy * xpv, det, FB, sat);
                    nv = div_round(yy * xph - xx * yph, det, FB, sat);
                    code = CASE_UNIQUE;
                    sat = sat | satx | saty;
                end else begin
                    tpx = hs * xph + vs * xpv;
                    tpy = hs * yph + vs * ypv;
                    if (tpx != 0 && tpy != 0) begin
                        fx = div_round(xx, tpx, 2 * FB, sat);
                        fy = div_round(yy, tpy, 2 * FB, sat);
                        m  = (fx + fy) < 0 ? -(fx + fy) : (fx + fy);
                        m  = (m + 1) >> 1;
                        f  = (fx + fy) < 0 ? -$signed(m) : $signed(m);
                        code = CASE_AVG;
                        sat = sat | satx | saty;
                    end else if (tpx != 0) begin
                        f = div_round(xx, tpx, 2 * FB, sat);
                        code = CASE_XRATIO;
                        sat = sat | satx;
                    end else if (tpy != 0) begin
                        f = div_round(yy, tpy, 2 * FB, sat);
                        code = CASE_YRATIO;
                        sat = sat | saty;
                    end
                    if (code != CASE_KEEP) begin
                        nh = scale_by(hs, f, sat);
                        nv = scale_by(vs, f, sat);
                    end
                end
            end
            r.nh = nh[31:0];
            r.nv = nv[31:0];
            r.code = code;
            r.sat = sat;
            return r;
        endfunction

        function void note_request(solve_req_t w);
            expected_fits.push_back(predict_fit(w));
        endfunction

        function void check_result(fit_t got);
            fit_t want;
            if (expected_fits.size() == 0) begin
                $display("%0t: result with nothing pending: h=%h v=%h case=%0d sat=%b",
                         $time, got.nh, got.nv, got.code, got.sat);
                errors++;
                return;
            end
            want = expected_fits.pop_front();
            if (got.nh !== want.nh) begin
                $display("%0t: new_hscale expected %h got %h", $time, want.nh, got.nh);
                errors++;
            end
            if (got.nv !== want.nv) begin
                $display("%0t: new_vscale expected %h got %h", $time, want.nv, got.nv);
                errors++;
            end
            if (got.code !== want.code) begin
                $display("%0t: case_taken expected %0d got %0d", $time, want.code, got.code);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated expected %b got %b", $time, want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_wdata;
    sfs_in_if             req ();
    sfs_out_if            rsp ();
    fit_ledger            ledger;
    bit                   calm_req;
    bit                   calm_rsp;
    int                   idle_cycles;

    scale_factor_solver_2x2_core #(.FRAC_BITS(FB)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] picks[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1,
                                  32'hFFFF_FFFF, 32'h0001_0000};
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            2: return picks[$urandom_range(0, 5)];
            default: return 32'h0001_0000 + $urandom_range(0, 32'h4000) - 32'h2000;
        endcase
    endfunction

    function automatic solve_req_t rand_solve();
        solve_req_t w;
        int r;
        w.tx = rand_word(); w.ty = rand_word();
        w.ox = rand_word(); w.oy = rand_word();
        w.hs = rand_word(); w.vs = rand_word();
        w.tw = 31'(rand_word()); w.th = 31'(rand_word());
        if ($urandom_range(0, 2) == 0) begin
            w.tw = 31'($urandom_range(0, 32'h0040_0000));
            w.th = 31'($urandom_range(0, 32'h0040_0000));
        end
        r = $urandom_range(0, 9);
        w.kx = (r < 3) || (r == 9);
        w.ky = (r >= 3 && r < 6) || (r == 9);
        return w;
    endfunction

    function automatic solve_req_t mk_solve(logic [31:0] tx, ty, ox, oy, hs, vs,
                                            logic [30:0] tw, th, logic kx, ky);
        solve_req_t w;
        w.tx = tx; w.ty = ty; w.ox = ox; w.oy = oy; w.hs = hs; w.vs = vs;
        w.tw = tw; w.th = th; w.kx = kx; w.ky = ky;
        return w;
    endfunction

    // Write all coefficients back to back; the block is idle here
    task automatic load_coefs(logic [31:0] c[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= c[i];
            ledger.coef[i] = c[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic void make_coefs(int kind, output logic [31:0] c[8]);
        logic [31:0] a, b, k;
        foreach (c[i]) c[i] = rand_word();
        case (kind)
            0: foreach (c[i]) c[i] = $urandom;
            1: foreach (c[i]) c[i] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: begin
                // singular system: y row a multiple of the x row
                a = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                b = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                k = $urandom_range(0, 4) - 2;
                c[REG_X_PER_HSCALE] = a;
                c[REG_X_PER_VSCALE] = b;
                c[REG_Y_PER_HSCALE] = $signed(a) * $signed(k);
                c[REG_Y_PER_VSCALE] = $signed(b) * $signed(k);
            end
            3: begin
                c[REG_Y_PER_HSCALE] = '0;
                c[REG_X_PER_VSCALE] = '0;
            end
            4: foreach (c[i]) c[i] = 32'h7FFF_FFFF;
            5: foreach (c[i]) c[i] = 32'h8000_0000;
            6: foreach (c[i]) c[i] = '0;
            default: ;
        endcase
    endfunction

    // Present one request word and hold it until taken
    task automatic send_solve(solve_req_t w);
        int gap;
        gap = pick_gap(calm_req);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.target_x    <= w.tx;
        req.target_y    <= w.ty;
        req.origin_x    <= w.ox;
        req.origin_y    <= w.oy;
        req.cur_hscale  <= w.hs;
        req.cur_vscale  <= w.vs;
        req.text_width  <= w.tw;
        req.text_height <= w.th;
        req.keep_x      <= w.kx;
        req.keep_y      <= w.ky;
        do @(posedge clk); while (!req.ready);
    endtask

    // Drop valid, wait for every result, then a settling wait longer than the pipeline depth
    task automatic drain();
        req.valid <= 1'b0;
        while (ledger.expected_fits.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Note accepted requests and check accepted results
    always @(posedge clk)
    begin
        solve_req_t w;
        fit_t got;
        if (rst_n && req.valid && req.ready)
        begin
            w = mk_solve(req.target_x, req.target_y, req.origin_x, req.origin_y,
                         req.cur_hscale, req.cur_vscale, req.text_width,
                         req.text_height, req.keep_x, req.keep_y);
            ledger.note_request(w);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.nh   = rsp.new_hscale;
            got.nv   = rsp.new_vscale;
            got.code = case_t'(rsp.case_taken);
            got.sat  = rsp.saturated;
            ledger.check_result(got);
        end
    end

    // Stall the result side at random, with calm stretches
    initial
    begin
        int gap;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 199) == 0) calm_rsp = !calm_rsp;
            gap = pick_gap(calm_rsp);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Watchdog: count busy cycles with no word moving
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else if (req.valid || ledger.expected_fits.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] c[8];
        ledger      = new();
        calm_req    = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        req.valid   = 1'b0;
        req.target_x = '0; req.target_y = '0; req.origin_x = '0; req.origin_y = '0;
        req.cur_hscale = '0; req.cur_vscale = '0; req.text_width = '0;
        req.text_height = '0; req.keep_x = 1'b0; req.keep_y = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coefficients at reset: every case leaves the factors unchanged
        send_solve(mk_solve(32'h10000, 32'h20000, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
        send_solve(mk_solve(32'h10000, 32'h20000, 0, 0, 32'h10000, 32'h10000, 0, 0, 1, 0));
        send_solve(mk_solve(32'h10000, 32'h20000, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 1));
        drain();

        // Regular system with unit-ish coefficients
        c = '{32'h1000, 32'h10000, 32'h8000, 32'h10000,
              32'hFFFF_0000, 32'h4000, 32'h20000, 32'hFFFF_0000};
        load_coefs(c);
        send_solve(mk_solve(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_solve(mk_solve(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0));
        send_solve(mk_solve(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0));
        send_solve(mk_solve(32'h30000, 32'h50000, 32'h1000, 32'h2000,
                            32'h10000, 32'h18000, 32'h8000, 32'h4000, 1, 0));
        send_solve(mk_solve(32'h30000, 32'h50000, 32'h1000, 32'h2000,
                            32'h10000, 32'h18000, 32'h8000, 32'h4000, 0, 1));
        send_solve(mk_solve(32'h30000, 32'h50000, 32'h1000, 32'h2000,
                            32'h10000, 32'h18000, 32'h8000, 32'h4000, 1, 1));
        // zero scales under a constraint: zero divisor
        send_solve(mk_solve(32'h30000, 32'h50000, 0, 0, 0, 0, 0, 0, 1, 0));
        send_solve(mk_solve(32'h30000, 32'h50000, 0, 0, 0, 0, 0, 0, 0, 1));
        drain();

        // Singular system: averaged, x-only and y-only ratios, unchanged
        c = '{0, 32'h10000, 32'h20000, 0, 0, 32'h20000, 32'h40000, 0};
        load_coefs(c);
        send_solve(mk_solve(32'h40000, 32'h90000, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
        send_solve(mk_solve(32'h40000, 32'h90000, 0, 0, 32'h20000, 32'hFFFF0000, 0, 0, 0, 0));
        send_solve(mk_solve(32'h7FFFFFFF, 32'h80000000, 0, 0, 1, 0, 0, 0, 0, 0));
        drain();
        c = '{0, 32'h10000, 32'h20000, 0, 0, 0, 0, 0};
        load_coefs(c);
        send_solve(mk_solve(32'h40000, 32'h90000, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
        drain();
        c = '{0, 0, 0, 0, 0, 32'h10000, 32'h20000, 0};
        load_coefs(c);
        send_solve(mk_solve(32'h40000, 32'h90000, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
        drain();

        // One coefficient per row: direct fit of a single factor
        c = '{0, 32'h10000, 0, 32'h100, 0, 0, 32'h8000, 32'h100};
        load_coefs(c);
        send_solve(mk_solve(32'h50000, 32'h60000, 0, 0, 32'h10000, 32'h10000,
                            32'h10000, 32'h10000, 1, 0));
        send_solve(mk_solve(32'h50000, 32'h60000, 0, 0, 32'h10000, 32'h10000,
                            32'h10000, 32'h10000, 0, 1));
        send_solve(mk_solve(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                            0, 0, 0, 0, 1, 0));
        drain();

        // Random phases over a spread of coefficient sets
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            make_coefs(p < 7 ? p : $urandom_range(0, 7), c);
            load_coefs(c);
            calm_req = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_solve(rand_solve());
            drain();
        end

        if (ledger.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
